>>> design/depth_sorted_hit_list_core_defines.svh
// ---------------------------------------------------------------------------
// depth_sorted_hit_list_core_defines
// assertion macros used by the hit list core
// ---------------------------------------------------------------------------
`ifndef DEPTH_SORTED_HIT_LIST_CORE_DEFINES_SVH
`define DEPTH_SORTED_HIT_LIST_CORE_DEFINES_SVH

// checked property, off while in reset
`define DSHL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also during reset
`define DSHL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dshl_pkg.sv
// ---------------------------------------------------------------------------
// dshl_pkg
// types and constants shared by the hit list core and its cells
// ---------------------------------------------------------------------------
package dshl_pkg;

    localparam int HIT_CAPACITY_DEF = 16;
    localparam int MASK_W           = 10;
    localparam int ID_W             = 32;
    localparam int DIST_W           = 32;
    localparam int DIST_VALID_BIT   = 5;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] MODE_UNSORTED  = 2'd0;
    localparam logic [1:0] MODE_NEAR_FAR  = 2'd1;
    localparam logic [1:0] MODE_FAR_NEAR  = 2'd2;

    typedef struct packed {
        logic [MASK_W-1:0]        mask;
        logic signed [ID_W-1:0]   pick_id;
        logic [DIST_W-1:0]        distance;
    } entry_t;

    typedef struct packed {
        logic add_en;
        logic sorted;
        logic far_near;
    } cell_ctrl_t;

endpackage

>>> design/depth_sorted_hit_list_core.sv
// the done strobe and the result are registered and come in the cycle after an accepted start
// throughput: one transaction per cycle, busy never rises
// each add resolves in a single pass along the slot chain (ripple of found flags)
// results cannot be stalled by the receiver
// reset: asynchronous, clears the hit count, sort mode and done strobe
// ---------------------------------------------------------------------------
// depth_sorted_hit_list_core
// bounded pick hit list in a chain of slot cells; near-far and far-near modes sort by distance
// ---------------------------------------------------------------------------
`include "depth_sorted_hit_list_core_defines.svh"

module depth_sorted_hit_list_core #(
    parameter int HIT_CAPACITY = dshl_pkg::HIT_CAPACITY_DEF,
    localparam int CW = $clog2(HIT_CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic [dshl_pkg::MASK_W-1:0]       hit_mask,
    input  logic signed [dshl_pkg::ID_W-1:0]  hit_pick_id,
    input  logic [dshl_pkg::DIST_W-1:0]       hit_distance,
    input  logic [3:0]                        read_index,
    input  logic [3:0]                        detail_select,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_wdata,
    output logic                              done,
    output logic                              ok,
    output logic [CW-1:0]                     count_now,
    output logic [dshl_pkg::MASK_W-1:0]       read_mask,
    output logic signed [dshl_pkg::ID_W-1:0]  read_pick_id,
    output logic [dshl_pkg::DIST_W-1:0]       read_distance,
    output logic                              detail_ok
);

    logic [1:0]           sort_mode_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 done_reg;
    logic                 ok_reg;
    logic                 ok_next;
    logic                 dok_reg;
    logic                 dok_next;
    dshl_pkg::entry_t     rd_reg;
    dshl_pkg::entry_t     rd_next;
    dshl_pkg::entry_t     rd_entry;
    dshl_pkg::entry_t     new_hit;
    dshl_pkg::cell_ctrl_t ctrl;
    dshl_pkg::entry_t     cell_q [HIT_CAPACITY];
    logic [HIT_CAPACITY:0] found;
    logic                 full;
    logic                 rd_valid;
    logic                 new_dvalid;
    logic                 mode_sorted;
    logic                 prepend;

    assign busy       = 1'b0;
    assign full       = (count_reg == CW'(HIT_CAPACITY));
    assign new_dvalid = hit_mask[dshl_pkg::DIST_VALID_BIT];
    assign mode_sorted = (sort_mode_reg == dshl_pkg::MODE_NEAR_FAR) ||
                         (sort_mode_reg == dshl_pkg::MODE_FAR_NEAR);
    assign prepend    = new_dvalid && !mode_sorted;

    assign new_hit.mask     = hit_mask;
    assign new_hit.pick_id  = hit_pick_id;
    assign new_hit.distance = hit_distance;

    assign ctrl.add_en   = start && (cmd == dshl_pkg::CMD_ADD) && !full;
    assign ctrl.sorted   = new_dvalid && mode_sorted;
    assign ctrl.far_near = (sort_mode_reg == dshl_pkg::MODE_FAR_NEAR);

    assign found[0] = 1'b0;

    for (genvar i = 0; i < HIT_CAPACITY; i++)
    begin : g_cell
        dshl_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .head       ((i == 0) && prepend),
            .occupied   (CW'(i) < count_reg),
            .at_end     (CW'(i) == count_reg),
            .new_hit    (new_hit),
            .left_entry ((i == 0) ? new_hit : cell_q[(i == 0) ? 0 : i - 1]),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .entry      (cell_q[i])
        );
    end

    // read port
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < HIT_CAPACITY; i++)
        begin
            if (i == int'(read_index))
            begin
                rd_entry = cell_q[i];
            end
        end
        rd_valid = int'(read_index) < int'(count_reg);
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        dok_next   = 1'b0;
        if (start)
        begin
            unique case (cmd)
                dshl_pkg::CMD_ADD:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                dshl_pkg::CMD_READ:
                begin
                    if (rd_valid)
                    begin
                        ok_next = 1'b1;
                        rd_next = rd_entry;
                        if (detail_select < 4'(dshl_pkg::MASK_W))
                        begin
                            dok_next = rd_entry.mask[detail_select];
                        end
                    end
                end
                dshl_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg <= dshl_pkg::MODE_UNSORTED;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sort_mode_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        rd_reg  <= rd_next;
        dok_reg <= dok_next;
    end

    assign done          = done_reg;
    assign ok            = ok_reg;
    assign count_now     = count_reg;
    assign read_mask     = rd_reg.mask;
    assign read_pick_id  = rd_reg.pick_id;
    assign read_distance = rd_reg.distance;
    assign detail_ok     = dok_reg;

    `DSHL_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(HIT_CAPACITY), "hit count beyond capacity")
    `DSHL_ASSERT(a_done_follows, (start && !busy) |=> done, "missing done after transaction")
    `DSHL_ASSERT(a_no_spurious_done, !start |=> !done, "done without transaction")
    `DSHL_ASSERT(a_full_reject, (start && cmd == dshl_pkg::CMD_ADD && full) |=> (full && !ok), "add accepted on full list")
    `DSHL_ASSERT(a_add_count, (start && cmd == dshl_pkg::CMD_ADD && !full) |=> (count_reg == $past(count_reg) + CW'(1)), "add did not grow count")
    `DSHL_ASSERT(a_clear_count, (start && cmd == dshl_pkg::CMD_CLEAR) |=> (count_reg == '0 && ok), "clear did not empty list")

endmodule

>>> design/dshl_cell.sv
// ---------------------------------------------------------------------------
// dshl_cell
// one list slot: compares the new hit against its entry and either holds,
// takes the new hit, or takes its left neighbor's entry
// ---------------------------------------------------------------------------
module dshl_cell (
    input  logic                 clk,
    input  dshl_pkg::cell_ctrl_t ctrl,
    input  logic                 head,
    input  logic                 occupied,
    input  logic                 at_end,
    input  dshl_pkg::entry_t     new_hit,
    input  dshl_pkg::entry_t     left_entry,
    input  logic                 found_in,
    output logic                 found_out,
    output dshl_pkg::entry_t     entry
);

    dshl_pkg::entry_t entry_reg;
    dshl_pkg::entry_t entry_next;
    logic             dist_hit;
    logic             qual;

    always_comb
    begin
        if (ctrl.far_near)
        begin
            dist_hit = entry_reg.distance < new_hit.distance;
        end
        else
        begin
            dist_hit = entry_reg.distance > new_hit.distance;
        end
        qual = head | (ctrl.sorted & occupied &
                       entry_reg.mask[dshl_pkg::DIST_VALID_BIT] & dist_hit);
    end

    assign found_out = found_in | qual;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.add_en)
        begin
            priority if (found_in)
            begin
                entry_next = left_entry;
            end
            else if (qual || at_end)
            begin
                entry_next = new_hit;
            end
            else
            begin
                entry_next = entry_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
